### design/deq_pkg.sv
// Package for the double-ended queue unit: sizes, request and status codes,
// payload structs and the controller-to-datapath command struct.
// No dependencies.
package deq_pkg;

  localparam int DEPTH  = 256;
  localparam int DATA_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int KIND_W = 3;
  localparam int STAT_W = 2;

  // Request codes
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd4;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped;
    logic [STAT_W-1:0]        status;
    logic [CNT_W-1:0]         count;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
  } out_item_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch;     // capture the incoming request
    logic rd_pop;    // read the entry a pop would remove
    logic update;    // write the store and move the pointers
    logic rd_ends;   // read the front and back entries
    logic load_out;  // load the result register
  } dp_cmd_t;

endpackage

### design/deq_ctrl.sv
// Controller for the double-ended queue unit: sequences one request through
// read, update, read-back and result load, and owns both handshakes.
// Depends on deq_pkg.
module deq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output deq_pkg::dp_cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_RD_POP = 5'b00010,
    ST_UPDATE = 5'b00100,
    ST_RD_END = 5'b01000,
    ST_LOAD   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   can_load;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  // The result register is free when empty or being drained this cycle
  assign can_load  = !out_valid_r || out_ready;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_RD_POP;
        end
      end
      ST_RD_POP: begin
        cmd.rd_pop = 1'b1;
        state_nxt  = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_RD_END;
      end
      ST_RD_END: begin
        cmd.rd_ends = 1'b1;
        state_nxt   = ST_LOAD;
      end
      ST_LOAD: begin
        if (can_load) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold the result until transfer, set it on load
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### design/deq_dp.sv
// Datapath for the double-ended queue unit: ring store, front pointer,
// element count, request latch and result register.
// Depends on deq_pkg.
module deq_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  deq_pkg::dp_cmd_t   cmd,
  input  deq_pkg::in_item_t  in_data,
  output deq_pkg::out_item_t out_data
);

  localparam int IDX_W  = deq_pkg::IDX_W;
  localparam int CNT_W  = deq_pkg::CNT_W;
  localparam int DATA_W = deq_pkg::DATA_W;

  logic [DATA_W-1:0] ring_r [deq_pkg::DEPTH];

  logic [deq_pkg::KIND_W-1:0] kind_r;
  logic [DATA_W-1:0]          value_r;
  logic [IDX_W-1:0]           front_r, front_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [DATA_W-1:0]          popped_r, popped_nxt;
  logic [deq_pkg::STAT_W-1:0] status_r, status_nxt;
  logic [DATA_W-1:0]          rd_a_r, rd_b_r;
  deq_pkg::out_item_t         out_r;

  logic [IDX_W-1:0] back_slot;
  logic [IDX_W-1:0] tail_slot;
  logic [IDX_W-1:0] rd_a_addr;
  logic [IDX_W-1:0] wr_addr;
  logic             wr_en;
  logic             full;
  logic             empty;

  // Ring addressing wraps naturally at the index width
  assign back_slot = front_r + count_r[IDX_W-1:0] - IDX_W'(1);
  assign tail_slot = front_r + count_r[IDX_W-1:0];
  assign full      = (count_r == CNT_W'(deq_pkg::DEPTH));
  assign empty     = (count_r == '0);
  assign rd_a_addr = (cmd.rd_pop && kind_r == deq_pkg::KIND_POP_BACK) ? back_slot : front_r;

  // Apply the request to pointers and store
  always_comb begin
    front_nxt  = front_r;
    count_nxt  = count_r;
    popped_nxt = '0;
    status_nxt = deq_pkg::STAT_OK;
    wr_en      = 1'b0;
    wr_addr    = tail_slot;
    case (kind_r)
      deq_pkg::KIND_PUSH_FRONT: begin
        if (full) begin
          status_nxt = deq_pkg::STAT_FULL;
        end else begin
          front_nxt = front_r - IDX_W'(1);
          wr_addr   = front_r - IDX_W'(1);
          wr_en     = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      deq_pkg::KIND_PUSH_BACK: begin
        if (full) begin
          status_nxt = deq_pkg::STAT_FULL;
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      deq_pkg::KIND_POP_FRONT: begin
        if (empty) begin
          status_nxt = deq_pkg::STAT_EMPTY;
        end else begin
          popped_nxt = rd_a_r;
          front_nxt  = front_r + IDX_W'(1);
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      deq_pkg::KIND_POP_BACK: begin
        if (empty) begin
          status_nxt = deq_pkg::STAT_EMPTY;
        end else begin
          popped_nxt = rd_a_r;
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      deq_pkg::KIND_CLEAR: begin
        front_nxt = '0;
        count_nxt = '0;
      end
      default: ;
    endcase
  end

  // Ring store: one write port, two registered read ports, read in the
  // pop-read and read-back steps and held otherwise
  always_ff @(posedge clk) begin
    if (cmd.update && wr_en) ring_r[wr_addr] <= value_r;
    if (cmd.rd_pop || cmd.rd_ends) begin
      rd_a_r <= ring_r[rd_a_addr];
      rd_b_r <= ring_r[back_slot];
    end
  end

  // Control state: pointer and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else if (cmd.update) begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r  <= in_data.kind;
      value_r <= in_data.value;
    end
    if (cmd.update) begin
      popped_r <= popped_nxt;
      status_r <= status_nxt;
    end
    if (cmd.load_out) begin
      out_r.popped      <= popped_r;
      out_r.status      <= status_r;
      out_r.count       <= count_r;
      out_r.front_value <= empty ? '0 : rd_a_r;
      out_r.back_value  <= empty ? '0 : rd_b_r;
    end
  end

  assign out_data = out_r;

endmodule

### design/double_ended_queue_unit.sv
// Top level of the double-ended queue unit: joins the controller and the
// datapath. Depends on deq_pkg, deq_ctrl and deq_dp.
//
//   Channel   Ports                          Carries
//   input     in_valid, in_ready, in_data    request kind and word to push
//   result    out_valid, out_ready, out_data popped word, status, count, ends
//
// A request passes from its transfer to result valid through pop read, store
// write and pointer update, read-back of the new ends, and result load.
// in_ready returns only after the load, so no new request enters meanwhile.
// A waiting result does not block the next transfer in; a result still held
// by out_ready at the next load stalls the controller in its load step.
// rst_n (synchronous) empties the queue; store contents are not cleared.
module double_ended_queue_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  deq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output deq_pkg::out_item_t out_data
);

  deq_pkg::dp_cmd_t cmd;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  deq_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

### bench/double_ended_queue_unit_tb.sv
// Self-checking bench for double_ended_queue_unit: a directed table of requests,
// then random fill, drain and mixed traffic, all scored against a local deque
// model. Depends on deq_pkg and the double_ended_queue_unit RTL.
`timescale 1ns / 1ps

module double_ended_queue_unit_tb;

  localparam int DEPTH  = deq_pkg::DEPTH;
  localparam int DATA_W = deq_pkg::DATA_W;
  localparam int IDX_W  = deq_pkg::IDX_W;
  localparam int CNT_W  = deq_pkg::CNT_W;
  localparam int KIND_W = deq_pkg::KIND_W;
  localparam int STAT_W = deq_pkg::STAT_W;

  localparam int HALF_PERIOD  = 10;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 10;
  localparam int IDLE_PCT     = 7;

  // Request codes the block ignores
  localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_C = 3'd7;

  typedef struct {
    deq_pkg::in_item_t  req;
    bit                 typed;
    deq_pkg::out_item_t want;
  } step_row_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  deq_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  deq_pkg::out_item_t out_data;

  // Expectation riding along with the request currently offered
  bit                 tag_typed = 1'b0;
  deq_pkg::out_item_t tag_want  = '0;

  // Local deque model
  logic signed [DATA_W-1:0] ring_copy [DEPTH];
  logic [IDX_W-1:0]         head_slot;
  logic [CNT_W-1:0]         held_words;

  deq_pkg::out_item_t awaited_results [$];
  step_row_t plan [$];
  int        mismatches    = 0;
  int        requests_in   = 0;
  int        quiet_cycles  = 0;
  bit        calm          = 1'b0;
  int        gen_count     = 0;
  int        full_refusals = 0;
  int        empty_refusals = 0;

  double_ended_queue_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Apply one request to the model and return the result it should give
  function automatic deq_pkg::out_item_t deque_apply(deq_pkg::in_item_t req);
    deq_pkg::out_item_t res;
    logic [IDX_W-1:0]   slot;
    res = '0;
    case (req.kind)
      deq_pkg::KIND_PUSH_FRONT: begin
        if (held_words == CNT_W'(DEPTH)) begin
          res.status = deq_pkg::STAT_FULL;
        end else begin
          head_slot = head_slot - IDX_W'(1);
          ring_copy[head_slot] = req.value;
          held_words = held_words + CNT_W'(1);
        end
      end
      deq_pkg::KIND_PUSH_BACK: begin
        if (held_words == CNT_W'(DEPTH)) begin
          res.status = deq_pkg::STAT_FULL;
        end else begin
          slot = head_slot + held_words[IDX_W-1:0];
          ring_copy[slot] = req.value;
          held_words = held_words + CNT_W'(1);
        end
      end
      deq_pkg::KIND_POP_FRONT: begin
        if (held_words == '0) begin
          res.status = deq_pkg::STAT_EMPTY;
        end else begin
          res.popped = ring_copy[head_slot];
          head_slot = head_slot + IDX_W'(1);
          held_words = held_words - CNT_W'(1);
        end
      end
      deq_pkg::KIND_POP_BACK: begin
        if (held_words == '0) begin
          res.status = deq_pkg::STAT_EMPTY;
        end else begin
          slot = head_slot + held_words[IDX_W-1:0] - IDX_W'(1);
          res.popped = ring_copy[slot];
          held_words = held_words - CNT_W'(1);
        end
      end
      deq_pkg::KIND_CLEAR: begin
        held_words = '0;
        head_slot = '0;
      end
      default: ;
    endcase
    res.count = held_words;
    if (held_words != '0) begin
      slot = head_slot + held_words[IDX_W-1:0] - IDX_W'(1);
      res.front_value = ring_copy[head_slot];
      res.back_value = ring_copy[slot];
    end
    return res;
  endfunction

  function automatic step_row_t step_row(logic [KIND_W-1:0] kind, logic signed [DATA_W-1:0] value,
                                         bit typed, logic signed [DATA_W-1:0] popped,
                                         logic [STAT_W-1:0] status, int count,
                                         logic signed [DATA_W-1:0] front,
                                         logic signed [DATA_W-1:0] back);
    step_row_t r;
    r.req.kind = kind;
    r.req.value = value;
    r.typed = typed;
    r.want.popped = popped;
    r.want.status = status;
    r.want.count = CNT_W'(count);
    r.want.front_value = front;
    r.want.back_value = back;
    return r;
  endfunction

  task automatic check_field(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h actual %h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Predict on every request transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      head_slot = '0;
      held_words = '0;
    end else if (in_valid && in_ready) begin
      deq_pkg::out_item_t pred;
      pred = deque_apply(in_data);
      awaited_results.push_back(tag_typed ? tag_want : pred);
      requests_in++;
    end
  end

  // Score every result transfer against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      deq_pkg::out_item_t want;
      if (awaited_results.size() == 0) begin
        $display("%0t ns: result with nothing expected, actual %h", $time, out_data);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        check_field("popped", want.popped, out_data.popped);
        check_field("status", DATA_W'(want.status), DATA_W'(out_data.status));
        check_field("count", DATA_W'(want.count), DATA_W'(out_data.count));
        check_field("front_value", want.front_value, out_data.front_value);
        check_field("back_value", want.back_value, out_data.back_value);
      end
    end
  end

  // Watchdog: end the run after a long stretch without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t ns: watchdog, no transfer for %0d cycles", $time, quiet_cycles);
        $display("** double_ended_queue_unit: FAILED **");
        $finish;
      end
    end
  end

  // Result side: random back-pressure, one long hold-off while the queue fills
  initial begin : result_sink
    bit held_once;
    held_once = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      @(posedge clk);
      if (!held_once && requests_in >= 120) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held_once = 1'b1;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Offer one request and hold it until transfer; call at a rising edge
  task automatic send_req(deq_pkg::in_item_t req, bit typed, deq_pkg::out_item_t want);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    tag_typed <= typed;
    tag_want <= want;
    do @(posedge clk); while (!in_ready);
    // Track occupancy to steer the random traffic
    case (req.kind)
      deq_pkg::KIND_PUSH_FRONT, deq_pkg::KIND_PUSH_BACK: begin
        if (gen_count == DEPTH) full_refusals++;
        else gen_count++;
      end
      deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_POP_BACK: begin
        if (gen_count == 0) empty_refusals++;
        else gen_count--;
      end
      deq_pkg::KIND_CLEAR: gen_count = 0;
      default: ;
    endcase
  endtask

  task automatic send_random(int push_pct, int noise_pct, bit with_clear);
    deq_pkg::in_item_t req;
    int                pick;
    pick = $urandom_range(99);
    req.value = $urandom;
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0: req.value = 32'sh7FFF_FFFF;
        1: req.value = 32'sh8000_0000;
        2: req.value = '0;
        default: req.value = '1;
      endcase
    end
    if (pick < noise_pct) begin
      if (with_clear && $urandom_range(3) == 0) req.kind = deq_pkg::KIND_CLEAR;
      else req.kind = KIND_W'($urandom_range(KIND_SPARE_C, KIND_SPARE_A));
    end else if (pick < noise_pct + push_pct) begin
      req.kind = $urandom_range(1) ? deq_pkg::KIND_PUSH_BACK : deq_pkg::KIND_PUSH_FRONT;
    end else begin
      req.kind = $urandom_range(1) ? deq_pkg::KIND_POP_BACK : deq_pkg::KIND_POP_FRONT;
    end
    send_req(req, 1'b0, '0);
  endtask

  // Drop valid and wait until every expected result has been seen
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  initial begin : request_source
    // Directed table: typed expectation where obvious, model otherwise
    plan.push_back(step_row(deq_pkg::KIND_POP_FRONT, 0, 1'b1, 0, deq_pkg::STAT_EMPTY,
                            0, 0, 0));
    plan.push_back(step_row(deq_pkg::KIND_POP_BACK, -1, 1'b1, 0, deq_pkg::STAT_EMPTY,
                            0, 0, 0));
    plan.push_back(step_row(KIND_SPARE_A, 5, 1'b1, 0, deq_pkg::STAT_OK, 0, 0, 0));
    plan.push_back(step_row(deq_pkg::KIND_PUSH_BACK, 32'sh7FFF_FFFF, 1'b1, 0,
                            deq_pkg::STAT_OK, 1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    plan.push_back(step_row(deq_pkg::KIND_PUSH_FRONT, 32'sh8000_0000, 1'b1, 0,
                            deq_pkg::STAT_OK, 2, 32'sh8000_0000, 32'sh7FFF_FFFF));
    plan.push_back(step_row(deq_pkg::KIND_PUSH_BACK, -1, 1'b1, 0, deq_pkg::STAT_OK, 3,
                            32'sh8000_0000, -1));
    plan.push_back(step_row(deq_pkg::KIND_PUSH_FRONT, 0, 1'b1, 0, deq_pkg::STAT_OK, 4,
                            0, -1));
    plan.push_back(step_row(KIND_SPARE_B, 32'sh5A5A_5A5A, 1'b0, 0, deq_pkg::STAT_OK,
                            0, 0, 0));
    plan.push_back(step_row(KIND_SPARE_C, -1, 1'b0, 0, deq_pkg::STAT_OK, 0, 0, 0));
    plan.push_back(step_row(deq_pkg::KIND_POP_FRONT, 7, 1'b1, 0, deq_pkg::STAT_OK, 3,
                            32'sh8000_0000, -1));
    plan.push_back(step_row(deq_pkg::KIND_POP_BACK, 9, 1'b1, -1, deq_pkg::STAT_OK, 2,
                            32'sh8000_0000, 32'sh7FFF_FFFF));
    plan.push_back(step_row(deq_pkg::KIND_PUSH_FRONT, 32'sh5555_5555, 1'b0, 0,
                            deq_pkg::STAT_OK, 0, 0, 0));
    plan.push_back(step_row(deq_pkg::KIND_PUSH_BACK, 32'shAAAA_AAAA, 1'b0, 0,
                            deq_pkg::STAT_OK, 0, 0, 0));
    plan.push_back(step_row(deq_pkg::KIND_POP_BACK, 0, 1'b0, 0, deq_pkg::STAT_OK,
                            0, 0, 0));
    plan.push_back(step_row(deq_pkg::KIND_CLEAR, 32'sh1234_5678, 1'b1, 0,
                            deq_pkg::STAT_OK, 0, 0, 0));
    plan.push_back(step_row(deq_pkg::KIND_POP_BACK, 0, 1'b1, 0, deq_pkg::STAT_EMPTY,
                            0, 0, 0));
    plan.push_back(step_row(deq_pkg::KIND_PUSH_FRONT, 32'sh1234_5678, 1'b1, 0,
                            deq_pkg::STAT_OK, 1, 32'sh1234_5678, 32'sh1234_5678));
    plan.push_back(step_row(deq_pkg::KIND_POP_BACK, 0, 1'b1, 32'sh1234_5678,
                            deq_pkg::STAT_OK, 0, 0, 0));
    plan.push_back(step_row(deq_pkg::KIND_PUSH_BACK, 1, 1'b0, 0, deq_pkg::STAT_OK,
                            0, 0, 0));
    plan.push_back(step_row(deq_pkg::KIND_POP_FRONT, 0, 1'b0, 0, deq_pkg::STAT_OK,
                            0, 0, 0));
    plan.push_back(step_row(deq_pkg::KIND_CLEAR, 0, 1'b1, 0, deq_pkg::STAT_OK, 0, 0, 0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) send_req(plan[i].req, plan[i].typed, plan[i].want);
    settle();

    // Fill to full, then keep pushing into the full queue a few times
    while (gen_count != DEPTH || full_refusals < 4) send_random(94, 2, 1'b0);
    settle();

    // Drain to empty, then pop the empty queue a few times
    while (gen_count != 0 || empty_refusals < 4) send_random(4, 2, 1'b0);

    // Mixed traffic, first with no idling on either side
    calm = 1'b1;
    repeat (60) send_random(45, 8, 1'b1);
    calm = 1'b0;
    repeat (30) send_random(55, 6, 1'b1);

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("** double_ended_queue_unit: PASSED **");
    end else begin
      $display("** double_ended_queue_unit: FAILED **");
    end
    $finish;
  end

endmodule
